>>> hdl/dae_pkg.sv
// Shared types and constants of the DNS answer address extractor.
// No dependencies; the other files that use it refer to it by scoped names.
`timescale 1ns / 1ps
package dae_pkg;

	localparam int MaxMsgBytes = 512;
	localparam int PosW        = 10;
	localparam int PaddrW      = 3;

	localparam logic [2:0] VERDICT_PARSED    = 3'd0;
	localparam logic [2:0] VERDICT_SHORT     = 3'd1;
	localparam logic [2:0] VERDICT_UNSOLICIT = 3'd2;
	localparam logic [2:0] VERDICT_EMPTY     = 3'd3;
	localparam logic [2:0] VERDICT_MALFORMED = 3'd4;

	localparam logic KIND_ADDRESS = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	localparam logic REG_IPV4_ENABLE = 1'b0;
	localparam logic REG_IPV6_ENABLE = 1'b1;

	typedef struct packed {
		logic ipv4_enable;
		logic ipv6_enable;
	} cfg_t;

	typedef struct packed {
		logic        kind;
		logic        is_v6;
		logic [63:0] address_high;
		logic [63:0] address_low;
		logic [2:0]  verdict;
		logic        last_result;
	} result_t;

	typedef struct packed {
		logic    v0;
		logic    v1;
		result_t r0;
		result_t r1;
	} push_t;

endpackage

>>> hdl/dae_if.sv
// Stream interfaces of the extractor: message bytes in, results out.
// Depends on nothing.
`timescale 1ns / 1ps
interface dae_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  msg_byte;
	logic        end_of_msg;
	logic [15:0] expected_id;
	modport source (output valid, msg_byte, end_of_msg, expected_id, input ready);
	modport sink (input valid, msg_byte, end_of_msg, expected_id, output ready);
endinterface

interface dae_out_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic        is_v6;
	logic [63:0] address_high;
	logic [63:0] address_low;
	logic [2:0]  verdict;
	logic        last_result;
	modport source (output valid, kind, is_v6, address_high, address_low, verdict,
		last_result, input ready);
	modport sink (input valid, kind, is_v6, address_high, address_low, verdict,
		last_result, output ready);
endinterface

>>> hdl/dns_answer_address_extractor.sv
// DNS answer address extractor: top level. Depends on dae_pkg, dae_if,
// dae_cfg, dae_parser and dae_out_fifo.
// Each result is written into the result queue register before it reaches the output.
// Throughput: one byte per cycle; a byte that gives two results needs two
// free queue slots, so the input waits while the four-entry queue holds more than two.
// Reset (arst_n low, asynchronous) clears parse state and queue; both enables set.
`timescale 1ns / 1ps
module dns_answer_address_extractor #(
	parameter int MAX_MSG_BYTES = dae_pkg::MaxMsgBytes
) (
	input  logic                       clk,
	input  logic                       arst_n,
	dae_in_if.sink                     msg,
	dae_out_if.source                  result,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [dae_pkg::PaddrW-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	dae_pkg::cfg_t    cfg;
	dae_pkg::push_t   push;
	dae_pkg::result_t head;
	logic             room, fire;

	// take a beat only when the queue can hold both results it may cause
	assign msg.ready = room;
	assign fire      = msg.valid & room;

	dae_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.cfg
	);

	dae_parser #(.MAX_MSG_BYTES(MAX_MSG_BYTES)) u_parser (
		.clk, .arst_n, .fire,
		.msg_byte(msg.msg_byte), .end_of_msg(msg.end_of_msg),
		.expected_id(msg.expected_id), .cfg, .push
	);

	dae_out_fifo u_fifo (
		.clk, .arst_n, .push, .room,
		.valid(result.valid), .ready(result.ready), .head
	);

	// unpack the queue head onto the result beat
	assign result.kind         = head.kind;
	assign result.is_v6        = head.is_v6;
	assign result.address_high = head.address_high;
	assign result.address_low  = head.address_low;
	assign result.verdict      = head.verdict;
	assign result.last_result  = head.last_result;
endmodule

>>> hdl/dae_cfg.sv
// APB-style register file holding the two family enables.
// Depends on dae_pkg.
`timescale 1ns / 1ps
module dae_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [dae_pkg::PaddrW-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	output dae_pkg::cfg_t             cfg
);
	dae_pkg::cfg_t cfg_q;
	logic          wr;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{ipv4_enable: 1'b1, ipv6_enable: 1'b1};
		end else if (wr) begin
			case (paddr[2])
				dae_pkg::REG_IPV4_ENABLE: cfg_q.ipv4_enable <= pwdata[0];
				dae_pkg::REG_IPV6_ENABLE: cfg_q.ipv6_enable <= pwdata[0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			dae_pkg::REG_IPV4_ENABLE: prdata = {31'd0, cfg_q.ipv4_enable};
			dae_pkg::REG_IPV6_ENABLE: prdata = {31'd0, cfg_q.ipv6_enable};
			default: prdata = 32'd0;
		endcase
	end

	assign cfg = cfg_q;
endmodule

>>> hdl/dae_parser.sv
// Byte-wise DNS response parse state and its per-byte update.
// Depends on dae_pkg; emits up to two results per accepted byte.
`timescale 1ns / 1ps
module dae_parser #(
	parameter int MAX_MSG_BYTES = dae_pkg::MaxMsgBytes
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fire,
	input  logic [7:0]    msg_byte,
	input  logic          end_of_msg,
	input  logic [15:0]   expected_id,
	input  dae_pkg::cfg_t cfg,
	output dae_pkg::push_t push
);
	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_QNAME  = 3'd1;
	localparam logic [2:0] PH_QFIXED = 3'd2;
	localparam logic [2:0] PH_ASTART = 3'd3;
	localparam logic [2:0] PH_ANAME  = 3'd4;
	localparam logic [2:0] PH_AFIXED = 3'd5;
	localparam logic [2:0] PH_ARDATA = 3'd6;
	localparam logic [2:0] PH_DONE   = 3'd7;
	localparam logic [15:0] TYPE_A    = 16'd1;
	localparam logic [15:0] TYPE_AAAA = 16'd28;
	localparam logic [dae_pkg::PosW-1:0] MaxPos = dae_pkg::PosW'(MAX_MSG_BYTES);

	logic [dae_pkg::PosW-1:0] pos_q, n_pos;
	logic [63:0]  hdr_q, n_hdr;
	logic [2:0]   ph_q, n_ph;
	logic [15:0]  q_q, n_q, a_q, n_a, rt_q, n_rt, rd_q, n_rd, id_q, n_id, idv;
	logic [7:0]   lbl_q, n_lbl;
	logic [3:0]   fix_q, n_fix;
	logic [127:0] addr_q, n_addr;
	logic [2:0]   mv_q, n_mv, vrd;
	logic         hit, extra;

	always_comb begin
		n_pos = pos_q; n_hdr = hdr_q; n_ph = ph_q; n_q = q_q; n_a = a_q;
		n_rt = rt_q; n_rd = rd_q; n_lbl = lbl_q; n_fix = fix_q; n_addr = addr_q;
		n_mv = mv_q; n_id = id_q; hit = 1'b0; extra = 1'b0; vrd = 3'd0;
		idv = (pos_q == '0) ? expected_id : id_q;
		n_id = idv;
		if (pos_q < MaxPos) begin
			n_pos = pos_q + 1'b1;
			case (ph_q)
				PH_HEADER: begin
					if (pos_q < dae_pkg::PosW'(8))
						n_hdr[8*(7-pos_q[2:0]) +: 8] = msg_byte;
					if (pos_q == dae_pkg::PosW'(11)) begin
						if (hdr_q[63:48] != idv || !hdr_q[47]) begin
							n_ph = PH_DONE; n_mv = dae_pkg::VERDICT_UNSOLICIT;
						end else begin
							n_q = hdr_q[31:16]; n_a = hdr_q[15:0];
							if (hdr_q[35:32] != 4'd0 || hdr_q[15:0] == 16'd0) begin
								n_ph = PH_DONE; n_mv = dae_pkg::VERDICT_EMPTY;
							end else begin
								n_ph = (hdr_q[31:16] != 16'd0) ? PH_QNAME : PH_ASTART;
							end
						end
					end
				end
				PH_QNAME, PH_ANAME, PH_ASTART: begin
					if (ph_q == PH_ASTART) begin
						n_ph = PH_ANAME; n_addr = '0; n_rt = '0; n_rd = '0; n_lbl = '0;
					end
					if (n_lbl != 8'd0) begin
						n_lbl = n_lbl - 1'b1;
					end else if (msg_byte == 8'd0 || msg_byte[7:6] == 2'b11) begin
						extra = (msg_byte != 8'd0);
						if (ph_q == PH_QNAME) begin
							n_ph = PH_QFIXED; n_fix = 4'd4 + {3'd0, extra};
						end else begin
							n_ph = PH_AFIXED; n_fix = 4'd10 + {3'd0, extra};
						end
					end else begin
						n_lbl = msg_byte;
					end
				end
				PH_QFIXED: begin
					n_fix = fix_q - 1'b1;
					if (n_fix == 4'd0) begin
						n_q = q_q - 1'b1;
						n_ph = (n_q != 16'd0) ? PH_QNAME : PH_ASTART;
					end
				end
				PH_AFIXED: begin
					if (fix_q == 4'd10 || fix_q == 4'd9) n_rt = {rt_q[7:0], msg_byte};
					if (fix_q == 4'd2 || fix_q == 4'd1) n_rd = {rd_q[7:0], msg_byte};
					n_fix = fix_q - 1'b1;
					if (n_fix == 4'd0) begin
						if (!((n_rt == TYPE_A && n_rd == 16'd4) ||
						      (n_rt == TYPE_AAAA && n_rd == 16'd16)))
							n_rt = '0;
						if (n_rd == 16'd0) begin
							n_a = a_q - 1'b1;
							n_ph = (n_a != 16'd0) ? PH_ASTART : PH_DONE;
							if (n_a == 16'd0) n_mv = dae_pkg::VERDICT_PARSED;
						end else begin
							n_ph = PH_ARDATA;
						end
					end
				end
				PH_ARDATA: begin
					n_addr = {addr_q[119:0], msg_byte};
					n_rd = rd_q - 1'b1;
					if (n_rd == 16'd0) begin
						n_a = a_q - 1'b1;
						n_ph = (n_a != 16'd0) ? PH_ASTART : PH_DONE;
						if (n_a == 16'd0) n_mv = dae_pkg::VERDICT_PARSED;
						hit = (rt_q == TYPE_A && cfg.ipv4_enable) ||
						      (rt_q == TYPE_AAAA && cfg.ipv6_enable);
					end
				end
				default: ;
			endcase
		end
		// end-of-message verdict from the state after this byte
		case (n_ph)
			PH_DONE:   vrd = n_mv;
			PH_HEADER: vrd = dae_pkg::VERDICT_SHORT;
			PH_QNAME, PH_QFIXED, PH_ASTART: vrd = dae_pkg::VERDICT_MALFORMED;
			default: vrd = (n_a != n_hdr[15:0] && n_hdr[41]) ?
				dae_pkg::VERDICT_PARSED : dae_pkg::VERDICT_MALFORMED;
		endcase
	end

	always_comb begin
		dae_pkg::result_t ra, rv;
		ra.kind = dae_pkg::KIND_ADDRESS;
		ra.is_v6 = (rt_q != TYPE_A);
		ra.address_high = (rt_q == TYPE_A) ? 64'd0 : n_addr[127:64];
		ra.address_low = (rt_q == TYPE_A) ? {32'd0, n_addr[31:0]} : n_addr[63:0];
		ra.verdict = dae_pkg::VERDICT_PARSED;
		ra.last_result = !end_of_msg;
		rv = '{kind: dae_pkg::KIND_VERDICT, is_v6: 1'b0, address_high: 64'd0,
			address_low: 64'd0, verdict: vrd, last_result: 1'b1};
		push.v0 = fire & (hit | end_of_msg);
		push.v1 = fire & hit & end_of_msg;
		push.r0 = hit ? ra : rv;
		push.r1 = rv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; hdr_q <= '0; ph_q <= PH_HEADER; q_q <= '0; a_q <= '0;
			rt_q <= '0; rd_q <= '0; lbl_q <= '0; fix_q <= '0; addr_q <= '0;
			mv_q <= '0; id_q <= '0;
		end else if (fire) begin
			if (end_of_msg) begin
				pos_q <= '0; hdr_q <= '0; ph_q <= PH_HEADER; q_q <= '0; a_q <= '0;
				rt_q <= '0; rd_q <= '0; lbl_q <= '0; fix_q <= '0; addr_q <= '0;
				mv_q <= '0; id_q <= '0;
			end else begin
				pos_q <= n_pos; hdr_q <= n_hdr; ph_q <= n_ph; q_q <= n_q; a_q <= n_a;
				rt_q <= n_rt; rd_q <= n_rd; lbl_q <= n_lbl; fix_q <= n_fix;
				addr_q <= n_addr; mv_q <= n_mv; id_q <= n_id;
			end
		end
	end
endmodule

>>> hdl/dae_out_fifo.sv
// Four-entry result queue: takes up to two results a cycle, gives one beat.
// Depends on dae_pkg.
`timescale 1ns / 1ps
module dae_out_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  dae_pkg::push_t   push,
	output logic             room,
	output logic             valid,
	input  logic             ready,
	output dae_pkg::result_t head
);
	dae_pkg::result_t mem_q [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;
	logic       pop;

	assign valid = (cnt_q != 3'd0);
	assign pop   = valid & ready;
	assign room  = (cnt_q <= 3'd2);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push.v0) mem_q[wr_q] <= push.r0;
		if (push.v1) mem_q[wr_q + 2'd1] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + {1'b0, push.v0} + {1'b0, push.v1};
			rd_q  <= rd_q + {1'b0, pop};
			cnt_q <= cnt_q + {2'd0, push.v0} + {2'd0, push.v1} - {2'd0, pop};
		end
	end
endmodule

>>> hdl/dae_checker.sv
// Port-level checks of the extractor, bound to the top level.
// Depends on dae_pkg.
`timescale 1ns / 1ps
module dae_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        kind,
	input logic        is_v6,
	input logic [63:0] address_high,
	input logic [63:0] address_low,
	input logic [2:0]  verdict,
	input logic        last_result
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result beat dropped");
	a_verdict_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == dae_pkg::KIND_VERDICT |->
		!is_v6 && address_high == 64'd0 && address_low == 64'd0 && last_result)
		else $error("verdict beat carries address bits");
	a_addr_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == dae_pkg::KIND_ADDRESS |->
		verdict == dae_pkg::VERDICT_PARSED &&
		(is_v6 || address_high == 64'd0) && (is_v6 || address_low[63:32] == 32'd0))
		else $error("address beat malformed");
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_result |=> out_valid &&
		kind == dae_pkg::KIND_VERDICT) else $error("address not followed by verdict");
endmodule

bind dns_answer_address_extractor dae_checker u_dae_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(result.valid), .out_ready(result.ready),
	.kind(result.kind), .is_v6(result.is_v6), .address_high(result.address_high),
	.address_low(result.address_low), .verdict(result.verdict),
	.last_result(result.last_result)
);
